FILE: hw/rtl/bdfa_pkg.sv
// bdfa_pkg: op codes, field widths and item/memory entry types
// for the bdd dfa successor lookup block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bdfa_pkg;

   localparam int OP_W    = 2;
   localparam int IDX_W   = 10;
   localparam int VAR_W   = 5;
   localparam int SYM_W   = 32;

   localparam logic [OP_W-1:0] OP_LOAD_NODE  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_STATE = 2'd1;
   localparam logic [OP_W-1:0] OP_STEP       = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] node_index;
      logic [IDX_W-1:0] low_child;
      logic [IDX_W-1:0] high_child;
      logic [VAR_W-1:0] var_index;
      logic             leaf;
      logic [IDX_W-1:0] dfa_state;
      logic [IDX_W-1:0] root_node;
      logic             accepting;
      logic [SYM_W-1:0] symbol;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0] next_state;
      logic             state_accepting;
      logic             walk_overflow;
   } rsp_payload_type;

   // one node of the shared decision diagram
   typedef struct packed {
      logic             is_leaf;
      logic [VAR_W-1:0] var_index;
      logic [IDX_W-1:0] high;
      logic [IDX_W-1:0] low;
   } node_entry_type;

   // per-state root pointer and accepting flag
   typedef struct packed {
      logic             accept_flag;
      logic [IDX_W-1:0] root;
   } state_entry_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bdfa_if.sv
// bdfa_req_if, bdfa_rsp_if: valid/ready channels carrying request and result items
// depends on bdfa_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bdfa_req_if import bdfa_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bdfa_rsp_if import bdfa_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bdfa_ram.sv
// bdfa_ram: single-port-write, single-port-read synchronous memory with a registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bdfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/bdd_dfa_successor_lookup_top.sv
// bdd_dfa_successor_lookup_top: dfa transition lookup over a shared decision diagram
// depends on bdfa_pkg, bdfa_if (bdfa_req_if, bdfa_rsp_if) and bdfa_ram
//
// Usage: req_ch takes one item at a time: a node load (writes the node store),
// a state load (writes the root/accepting table) or a step query. Every item
// gives exactly one result item on rsp_ch, in order. Both channels are
// valid/ready; an item moves at a rising edge with valid and ready high.
// A load or an unused op passes through S_EXEC and S_FINISH to the output
// register. A step reads the state table in S_ROOT, then reads the node store
// once per diagram node visited in S_NODE before S_FINISH; with a diagram
// ordered by variable a walk visits at most NVARS + 1 nodes. The walk through
// the node store read port sets the rate: one item is worked on at a time.
// A finished result sits in the output register while the next item is taken
// and worked on; that item then waits for the output register to free up, and
// req_ch.ready stays low until it has moved on. A stalled rsp_ch never loses or
// repeats an item.
// Reset clears the control state only; node and state tables hold no reset
// value and must be loaded before they are queried. There is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bdd_dfa_successor_lookup_top import bdfa_pkg::*; #(
   parameter int NODES  = 1024,
   parameter int STATES = 1024,
   parameter int NVARS  = 32
) (
   input  logic              clock,
   input  logic              reset,
   bdfa_req_if.sink          req_ch,
   bdfa_rsp_if.source        rsp_ch
);

   // only the first 1024 entries are addressable by the 10-bit fields
   localparam int NODE_DEPTH  = (NODES < 1024) ? NODES : 1024;
   localparam int STATE_DEPTH = (STATES < 1024) ? STATES : 1024;
   localparam int NIDX_W      = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
   localparam int SIDX_W      = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
   localparam int MOVE_W      = $clog2(NODES + 1);
   localparam int NODE_W      = $bits(node_entry_type);
   localparam int STATE_W     = $bits(state_entry_type);

   localparam logic [16:0]       NODES_LIM  = 17'(NODES);
   localparam logic [16:0]       STATES_LIM = 17'(STATES);
   localparam logic [6:0]        NVARS_LIM  = 7'(NVARS);
   localparam logic [MOVE_W-1:0] MOVES_MAX  = MOVE_W'(NODES);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_ROOT   = 3'd2;
   localparam logic [2:0] S_NODE   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]        state_ff, state_in;
   req_payload_type   item_ff, item_in;
   logic [MOVE_W-1:0] moves_ff, moves_in;
   logic              acc_ff, acc_in;
   rsp_payload_type   res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic              req_accept;
   logic              rsp_free;

   logic              node_wr_en;
   node_entry_type    node_wr_data;
   logic              node_rd_en;
   logic [IDX_W-1:0]  node_rd_addr;
   logic [NODE_W-1:0] node_rd_raw;
   node_entry_type    node_rd;

   logic              st_wr_en;
   state_entry_type   st_wr_data;
   logic [STATE_W-1:0] st_rd_raw;
   state_entry_type   st_rd;

   logic              st_in_range;
   logic [IDX_W-1:0]  root_sel;
   logic              sym_bit;
   logic [IDX_W-1:0]  child;

   assign req_accept    = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE);
   assign rsp_free      = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   assign node_rd = node_entry_type'(node_rd_raw);
   assign st_rd   = state_entry_type'(st_rd_raw);

   assign node_wr_data.is_leaf   = item_ff.leaf;
   assign node_wr_data.var_index = item_ff.var_index;
   assign node_wr_data.high      = item_ff.high_child;
   assign node_wr_data.low       = item_ff.low_child;
   assign st_wr_data.accept_flag = item_ff.accepting;
   assign st_wr_data.root        = item_ff.root_node;

   assign node_wr_en = (state_ff == S_EXEC) && (item_ff.op == OP_LOAD_NODE) &&
                       ({7'd0, item_ff.node_index} < NODES_LIM);
   assign st_wr_en   = (state_ff == S_EXEC) && (item_ff.op == OP_LOAD_STATE) &&
                       ({7'd0, item_ff.dfa_state} < STATES_LIM);

   assign st_in_range = ({7'd0, item_ff.dfa_state} < STATES_LIM);
   assign root_sel    = st_in_range ? st_rd.root : '0;

   // tested bit, zero when the variable is beyond the symbol width in use
   assign sym_bit = ({2'd0, node_rd.var_index} < NVARS_LIM) &&
                    item_ff.symbol[node_rd.var_index];
   assign child   = sym_bit ? node_rd.high : node_rd.low;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      moves_in     = moves_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      node_rd_en   = 1'b0;
      node_rd_addr = root_sel;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               item_in  = req_ch.payload;
               state_in = (req_ch.payload.op == OP_STEP) ? S_ROOT : S_EXEC;
            end
         end
         S_EXEC: begin
            res_in   = '0;
            state_in = S_FINISH;
         end
         S_ROOT: begin
            acc_in   = st_in_range && st_rd.accept_flag;
            moves_in = '0;
            res_in   = '0;
            res_in.state_accepting = st_in_range && st_rd.accept_flag;
            if ({7'd0, root_sel} < NODES_LIM) begin
               node_rd_en   = 1'b1;
               node_rd_addr = root_sel;
               state_in     = S_NODE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_NODE: begin
            res_in = '0;
            res_in.state_accepting = acc_ff;
            if (node_rd.is_leaf) begin
               res_in.next_state = node_rd.low;
               state_in          = S_FINISH;
            end else if (moves_ff >= MOVES_MAX) begin
               res_in.walk_overflow = 1'b1;
               state_in             = S_FINISH;
            end else begin
               moves_in = moves_ff + MOVE_W'(1);
               // a child beyond the store ends the walk as a zero leaf
               if ({7'd0, child} < NODES_LIM) begin
                  node_rd_en   = 1'b1;
                  node_rd_addr = child;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      moves_ff    <= moves_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   bdfa_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (item_ff.node_index[NIDX_W-1:0]),
      .wr_data (NODE_W'(node_wr_data)),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr[NIDX_W-1:0]),
      .rd_data (node_rd_raw)
   );

   bdfa_ram #(
      .WIDTH (STATE_W),
      .DEPTH (STATE_DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (item_ff.dfa_state[SIDX_W-1:0]),
      .wr_data (STATE_W'(st_wr_data)),
      .rd_en   (req_accept),
      .rd_addr (req_ch.payload.dfa_state[SIDX_W-1:0]),
      .rd_data (st_rd_raw)
   );

`ifndef SYNTHESIS
   a_ready_drops_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ch.ready)
      else $error("input taken while an item is in flight");

   a_moves_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NODE) |-> (moves_ff <= MOVES_MAX))
      else $error("walk move count beyond node count");

   a_result_only_from_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_ch.ready)) |-> (state_ff == S_FINISH))
      else $error("result register loaded outside finish");

   a_overflow_zero_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.walk_overflow) |-> (rsp_data_ff.next_state == '0))
      else $error("overflowed walk returned a nonzero state");

   a_no_write_during_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT || state_ff == S_NODE) |-> !(node_wr_en || st_wr_en))
      else $error("table write while a walk reads");
`endif

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// testbench: self-checking bench for bdd_dfa_successor_lookup_top, with a directed table,
// constrained-free random diagrams and queries, and an in-bench successor predictor
// depends on bdfa_pkg, bdfa_if and the block itself
`timescale 1ns / 1ps

module testbench;
   import bdfa_pkg::*;

   localparam int NODE_COUNT = 1024;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam rsp_payload_type NO_RESULT = '0;
   localparam int ITEM_GOAL = 1550;
   localparam int SHORT_WALK = 40;
   localparam int LONG_HOLD = 300;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      req_payload_type item;
      bit              typed;
      rsp_payload_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   bdfa_req_if req_ch ();
   bdfa_rsp_if rsp_ch ();

   bdd_dfa_successor_lookup_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the diagram store and the state tables
   logic [IDX_W-1:0] node_lo [NODE_COUNT];
   logic [IDX_W-1:0] node_hi [NODE_COUNT];
   logic [VAR_W-1:0] node_v [NODE_COUNT];
   logic             node_leaf [NODE_COUNT];
   bit               node_known [NODE_COUNT];
   logic [IDX_W-1:0] root_of [NODE_COUNT];
   logic             final_of [NODE_COUNT];
   logic [IDX_W-1:0] states_loaded [$];

   rsp_payload_type  successors_due [$];
   directed_row_type plan [$];

   int n_steps = 0;
   int n_overflows = 0;
   int n_node_loads = 0;
   int n_state_loads = 0;
   int n_unused = 0;
   int n_checked = 0;
   int failures = 0;
   int long_walks_left = 15;
   int stall_asked = 0;
   int stall_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   bit idling_on = 1'b1;

   function automatic req_payload_type random_payload();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(req_payload_type)-1:0];
   endfunction

   function automatic req_payload_type with_op(input req_payload_type p,
                                               input logic [OP_W-1:0] op);
      p.op = op;
      return p;
   endfunction

   function automatic req_payload_type node_item(input logic [IDX_W-1:0] idx, lo, hi,
                                                 input logic [VAR_W-1:0] v,
                                                 input logic is_leaf);
      req_payload_type p;
      p = with_op(random_payload(), OP_LOAD_NODE);
      p.node_index = idx;
      p.low_child = lo;
      p.high_child = hi;
      p.var_index = v;
      p.leaf = is_leaf;
      return p;
   endfunction

   function automatic req_payload_type state_item(input logic [IDX_W-1:0] st, root,
                                                  input logic acc);
      req_payload_type p;
      p = with_op(random_payload(), OP_LOAD_STATE);
      p.dfa_state = st;
      p.root_node = root;
      p.accepting = acc;
      return p;
   endfunction

   function automatic req_payload_type step_item(input logic [IDX_W-1:0] st,
                                                 input logic [SYM_W-1:0] sym);
      req_payload_type p;
      p = with_op(random_payload(), OP_STEP);
      p.dfa_state = st;
      p.symbol = sym;
      return p;
   endfunction

   // follows the diagram from a state's root; gap is the first unwritten node met, or -1
   function automatic void walk_diagram(input logic [IDX_W-1:0] st,
                                        input logic [SYM_W-1:0] sym,
                                        output rsp_payload_type res,
                                        output int moves, output int gap);
      logic [IDX_W-1:0] node;
      res = NO_RESULT;
      res.state_accepting = final_of[st];
      node = root_of[st];
      moves = 0;
      gap = -1;
      forever begin
         if (!node_known[node]) begin
            gap = int'(node);
            return;
         end
         if (node_leaf[node]) begin
            res.next_state = node_lo[node];
            return;
         end
         if (moves >= NODE_COUNT) begin
            res.walk_overflow = 1'b1;
            return;
         end
         // var index is 5 bits, so it never leaves the 32-bit symbol
         node = sym[node_v[node]] ? node_hi[node] : node_lo[node];
         moves++;
      end
   endfunction

   function automatic rsp_payload_type predict_lookup(input req_payload_type it);
      rsp_payload_type res;
      int moves, gap;
      res = NO_RESULT;
      case (it.op)
         OP_LOAD_NODE: begin
            node_lo[it.node_index] = it.low_child;
            node_hi[it.node_index] = it.high_child;
            node_v[it.node_index] = it.var_index;
            node_leaf[it.node_index] = it.leaf;
            node_known[it.node_index] = 1'b1;
            n_node_loads++;
         end
         OP_LOAD_STATE: begin
            root_of[it.dfa_state] = it.root_node;
            final_of[it.dfa_state] = it.accepting;
            states_loaded.push_back(it.dfa_state);
            n_state_loads++;
         end
         OP_STEP: begin
            walk_diagram(it.dfa_state, it.symbol, res, moves, gap);
            n_steps++;
            if (res.walk_overflow) n_overflows++;
         end
         default: n_unused++;
      endcase
      return res;
   endfunction

   task automatic send_item(input req_payload_type item, input bit typed,
                            input rsp_payload_type want);
      rsp_payload_type predicted;
      while (idling_on && $urandom_range(99) < 15) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (!req_ch.ready);
      predicted = predict_lookup(item);
      successors_due.push_back(typed ? want : predicted);
   endtask

   task automatic wait_all_results();
      req_ch.valid <= 1'b0;
      while (successors_due.size() != 0) @(posedge clock);
   endtask

   // patches unwritten nodes on the walk first, so no undefined entry is ever read
   task automatic query_state(input logic [IDX_W-1:0] st);
      logic [SYM_W-1:0] sym;
      rsp_payload_type res;
      int moves, gap;
      case ($urandom_range(9))
         0: sym = '0;
         1: sym = '1;
         default: sym = $urandom;
      endcase
      forever begin
         walk_diagram(st, sym, res, moves, gap);
         if (gap < 0) break;
         send_item(node_item(IDX_W'(gap), IDX_W'($urandom_range(1023)),
                             IDX_W'($urandom_range(1023)), VAR_W'($urandom_range(31)),
                             $urandom_range(99) < 70), 1'b0, NO_RESULT);
      end
      if (moves > SHORT_WALK) begin
         if (long_walks_left == 0) return;
         long_walks_left--;
      end
      send_item(step_item(st, sym), 1'b0, NO_RESULT);
   endtask

   // leaves first, then internal nodes whose children are nodes already written
   task automatic build_diagram();
      logic [IDX_W-1:0] made [$];
      logic [IDX_W-1:0] idx, st;
      int levels;
      repeat ($urandom_range(1, 3)) begin
         idx = IDX_W'($urandom_range(1023));
         send_item(node_item(idx, IDX_W'($urandom_range(1023)), IDX_W'($urandom_range(1023)),
                             VAR_W'($urandom_range(31)), 1'b1), 1'b0, NO_RESULT);
         made.push_back(idx);
      end
      levels = $urandom_range(1, 6);
      repeat (levels) begin
         repeat ($urandom_range(1, 2)) begin
            idx = IDX_W'($urandom_range(1023));
            send_item(node_item(idx, made[$urandom_range(made.size() - 1)],
                                made[$urandom_range(made.size() - 1)],
                                VAR_W'($urandom_range(31)), 1'b0), 1'b0, NO_RESULT);
            made.push_back(idx);
         end
      end
      st = IDX_W'($urandom_range(1023));
      send_item(state_item(st, made[$], 1'($urandom_range(1))), 1'b0, NO_RESULT);
      repeat ($urandom_range(2, 6)) query_state(st);
   endtask

   task automatic add_row(input req_payload_type item, input bit typed,
                          input rsp_payload_type want);
      directed_row_type r;
      r.item = item;
      r.typed = typed;
      r.want = want;
      plan.push_back(r);
   endtask

   // result side: checks every item against the oldest expectation, stalls at random
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (successors_due.size() == 0) begin
            $error("result item with nothing expected: %p", rsp_ch.payload);
            failures++;
         end else begin
            want = successors_due.pop_front();
            n_checked++;
            if (rsp_ch.payload.next_state !== want.next_state) begin
               $error("next_state: expected %0d, got %0d", want.next_state,
                      rsp_ch.payload.next_state);
               failures++;
            end
            if (rsp_ch.payload.state_accepting !== want.state_accepting) begin
               $error("state_accepting: expected %0d, got %0d", want.state_accepting,
                      rsp_ch.payload.state_accepting);
               failures++;
            end
            if (rsp_ch.payload.walk_overflow !== want.walk_overflow) begin
               $error("walk_overflow: expected %0d, got %0d", want.walk_overflow,
                      rsp_ch.payload.walk_overflow);
               failures++;
            end
         end
      end
      if (stall_served != stall_asked) begin
         stall_served = stall_asked;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !(idling_on && $urandom_range(99) < 15);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int total;
      bit held, paused;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      held = 1'b0;
      paused = 1'b0;

      add_row(with_op('1, OP_UNUSED), 1'b1, NO_RESULT);
      add_row(with_op('0, OP_UNUSED), 1'b1, NO_RESULT);
      add_row(node_item(10'd0, 10'd1023, 10'd0, 5'd0, 1'b1), 1'b1, NO_RESULT);
      add_row(node_item(10'd1, 10'd0, 10'd1023, 5'd31, 1'b1), 1'b1, NO_RESULT);
      add_row(node_item(10'd1023, 10'd1, 10'd0, 5'd31, 1'b0), 1'b1, NO_RESULT);
      add_row(node_item(10'd2, 10'd1023, 10'd1, 5'd0, 1'b0), 1'b1, NO_RESULT);
      // a leaf ignores its high child and variable
      add_row(node_item(10'd3, 10'd512, 10'd1023, 5'd31, 1'b1), 1'b1, NO_RESULT);
      add_row(state_item(10'd0, 10'd0, 1'b0), 1'b1, NO_RESULT);
      add_row(state_item(10'd1023, 10'd1023, 1'b1), 1'b1, NO_RESULT);
      add_row(state_item(10'd5, 10'd2, 1'b1), 1'b1, NO_RESULT);
      add_row(state_item(10'd1000, 10'd1000, 1'b1), 1'b1, NO_RESULT);
      // self loop: the walk never meets a leaf
      add_row(node_item(10'd1000, 10'd1000, 10'd1000, 5'd7, 1'b0), 1'b1, NO_RESULT);
      add_row(step_item(10'd0, 32'h0000_0000), 1'b1, {10'd1023, 1'b0, 1'b0});
      add_row(step_item(10'd0, 32'hFFFF_FFFF), 1'b1, {10'd1023, 1'b0, 1'b0});
      add_row(step_item(10'd1023, 32'h8000_0000), 1'b0, NO_RESULT);
      add_row(step_item(10'd1023, 32'h7FFF_FFFF), 1'b0, NO_RESULT);
      add_row(step_item(10'd5, 32'h0000_0000), 1'b0, NO_RESULT);
      add_row(step_item(10'd5, 32'hFFFF_FFFF), 1'b0, NO_RESULT);
      add_row(step_item(10'd1000, 32'h0000_0080), 1'b1, {10'd0, 1'b1, 1'b1});
      add_row(step_item(10'd1000, 32'hFFFF_FF7F), 1'b1, {10'd0, 1'b1, 1'b1});
      add_row(state_item(10'd0, 10'd3, 1'b1), 1'b1, NO_RESULT);
      add_row(step_item(10'd0, 32'h1234_5678), 1'b0, NO_RESULT);
      add_row(node_item(10'd1, 10'd1023, 10'd0, 5'd0, 1'b1), 1'b1, NO_RESULT);
      add_row(step_item(10'd5, 32'hFFFF_FFFF), 1'b0, NO_RESULT);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) send_item(plan[k].item, plan[k].typed, plan[k].want);
      wait_all_results();

      total = n_steps + n_node_loads + n_state_loads;
      while (total < ITEM_GOAL) begin
         if (!held && total >= 400) begin
            // receiver holds off while items keep coming
            held = 1'b1;
            stall_asked++;
         end
         if (!paused && total >= 800) begin
            paused = 1'b1;
            wait_all_results();
         end
         idling_on = !(total >= 1000 && total < 1200);
         case ($urandom_range(99)) inside
            [0:54]:  build_diagram();
            [55:79]: query_state(states_loaded[$urandom_range(states_loaded.size() - 1)]);
            [80:87]: send_item(with_op(random_payload(), OP_LOAD_NODE), 1'b0, NO_RESULT);
            [88:93]: send_item(with_op(random_payload(), OP_LOAD_STATE), 1'b0, NO_RESULT);
            default: send_item(with_op(random_payload(), OP_UNUSED), 1'b0, NO_RESULT);
         endcase
         total = n_steps + n_node_loads + n_state_loads;
      end

      wait_all_results();
      repeat (8) @(posedge clock);

      $display("covered %0d steps (%0d overflowed the walk), %0d node loads, %0d state loads,",
               n_steps, n_overflows, n_node_loads, n_state_loads);
      $display("%0d unused-op items; %0d results checked, %0d mismatches",
               n_unused, n_checked, failures);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: bdd_dfa_successor_lookup_top.f
hw/rtl/bdfa_pkg.sv
hw/rtl/bdfa_if.sv
hw/rtl/bdfa_ram.sv
hw/rtl/bdd_dfa_successor_lookup_top.sv
bench/testbench.sv
